>>> src/lmgm_pkg.sv
// lmgm_pkg: shared types, constants and the fixed address-range table
// for the sparse low-memory globals map. No dependencies.
`timescale 1ns / 1ps

package lmgm_pkg;

    localparam int TABLE_ENTRIES = 41;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;

    // size byte fields
    localparam int         SZ_CONST_BIT = 7;
    localparam int         SZ_TICK_BIT  = 6;
    localparam logic [7:0] SZ_WIDTH     = 8'h3F;

    // word index width: 8-bit entry index plus up to 31 words of offset
    localparam int WI_W = 9;

    typedef struct packed {
        logic       hit;
        logic [7:0] sz;
        logic [7:0] idx;
        logic [5:0] off;
    } lk_t;

    localparam logic [15:0] TBL_BASE [TABLE_ENTRIES] = '{
        16'h0102, 16'h0106, 16'h0144, 16'h0146, 16'h014A, 16'h0154, 16'h016A,
        16'h0172, 16'h017A, 16'h0220, 16'h031A, 16'h0800, 16'h0804, 16'h0814,
        16'h0818, 16'h0824, 16'h0830, 16'h0834, 16'h0908, 16'h0910, 16'h0934,
        16'h0980, 16'h0984, 16'h09D6, 16'h09DA, 16'h09DC, 16'h09DE, 16'h09E6,
        16'h09EA, 16'h09EE, 16'h09F2, 16'h0A02, 16'h0A06, 16'h0A0E, 16'h0A34,
        16'h0A3C, 16'h0A60, 16'h0A64, 16'h0A68, 16'h0BAA, 16'h0BFE
    };

    localparam logic [7:0] TBL_SZ [TABLE_ENTRIES] = '{
        8'h84, 8'h02, 8'h02, 8'h04, 8'h0A, 8'h02, 8'h44,
        8'h02, 8'h02, 8'h02, 8'h83, 8'h04, 8'h04, 8'h04,
        8'h04, 8'h04, 8'h04, 8'h08, 8'h04, 8'h20, 8'h02,
        8'h04, 8'h82, 8'h04, 8'h02, 8'h02, 8'h04, 8'h04,
        8'h04, 8'h04, 8'h04, 8'h84, 8'h84, 8'h0E, 8'h08,
        8'h08, 8'h02, 8'h04, 8'h04, 8'h02, 8'h02
    };

    localparam logic [7:0] TBL_IDX [TABLE_ENTRIES] = '{
        8'd72, 8'd0,  8'd1,  8'd2,  8'd4,  8'd9,  8'd10,
        8'd12, 8'd13, 8'd14, 8'hFF, 8'd15, 8'd17, 8'd19,
        8'd21, 8'd23, 8'd25, 8'd27, 8'd31, 8'd33, 8'd49,
        8'd50, 8'd3,  8'd52, 8'd54, 8'd55, 8'd56, 8'd58,
        8'd60, 8'd62, 8'd64, 8'h01, 8'hFF, 8'd66, 8'd73,
        8'd77, 8'd81, 8'd82, 8'd84, 8'd86, 8'd87
    };

    // bytes covered by an entry; a 3-wide constant is a long
    function automatic logic [6:0] lm_span(input logic [7:0] sz);
        logic [5:0] w;
        begin
            w = 6'(sz & SZ_WIDTH);
            lm_span = (w == 6'd3) ? 7'd4 : {1'b0, w};
        end
    endfunction

    // byte of a constant entry at offset off
    function automatic logic [7:0] lm_const_byte(input logic [7:0] sz,
                                                 input logic [7:0] idx,
                                                 input logic [5:0] off);
        logic [5:0]  w;
        logic [15:0] word;
        begin
            w    = 6'(sz & SZ_WIDTH);
            word = {{8{idx[7]}}, idx};
            if (w < 6'd2) begin
                lm_const_byte = idx;
            end else if (w == 6'd3 && off == 6'd0) begin
                lm_const_byte = 8'h00;
            end else begin
                lm_const_byte = off[0] ? word[7:0] : word[15:8];
            end
        end
    endfunction

endpackage

>>> src/lmgm_lookup.sv
// lmgm_lookup: matches one byte address against the range table.
// Depends on lmgm_pkg (table, lk_t).
`timescale 1ns / 1ps

module lmgm_lookup import lmgm_pkg::*; (
    input  logic [16:0] addr,
    output lk_t         lk
);

    // first matching entry wins, so scan from the back
    always_comb begin
        lk = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (addr >= {1'b0, TBL_BASE[i]} &&
                addr < ({1'b0, TBL_BASE[i]} + 17'(lm_span(TBL_SZ[i])))) begin
                lk.hit = 1'b1;
                lk.sz  = TBL_SZ[i];
                lk.idx = TBL_IDX[i];
                lk.off = 6'(addr - {1'b0, TBL_BASE[i]});
            end
        end
    end

endmodule

>>> src/low_memory_globals_map_core.sv
// low_memory_globals_map_core: sparse low-memory globals map, top level.
// Depends on lmgm_pkg and lmgm_lookup; holds the word store memory.
//
// Only IDLE accepts a word. RUN steps its bytes: one byte is looked up and
//   one store access made per cycle, single memory port. A read then folds
//   in its last byte in DRAIN; FIN loads the output register, and only then
//   is a new word taken. A bad length or operation goes straight to FIN.
// Reset: synchronous active-low aresetn clears control and the per-word
//   valid bits, so every store word reads as zero until written.
`timescale 1ns / 1ps

module low_memory_globals_map_core import lmgm_pkg::*; #(
    parameter int STORE_WORDS = 88
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_address,
    input  logic [2:0]  s_length,
    input  logic [31:0] s_write_data,
    input  logic [31:0] s_ticks,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_fault
);

    localparam int AW = $clog2(STORE_WORDS);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a word
    localparam logic [1:0] ST_RUN   = 2'd1;  // one byte per cycle
    localparam logic [1:0] ST_DRAIN = 2'd2;  // fold in the last read byte
    localparam logic [1:0] ST_FIN   = 2'd3;  // hand result to output reg

    logic [1:0]  state_reg, state_next;
    logic [1:0]  k_reg, k_next;

    // latched request
    logic [1:0]  op_reg;
    logic [15:0] addr_reg;
    logic [2:0]  len_reg;
    logic [31:0] wdata_reg;
    logic [31:0] ticks_reg;

    // result being built
    logic [31:0] acc_reg, acc_next;
    logic        fault_reg, fault_next;

    // read byte in flight: either from the store (arrives next cycle)
    // or a constant / tick byte known now
    logic        pend_valid_reg, pend_valid_next;
    logic        pend_mem_reg, pend_mem_next;
    logic        pend_half_reg, pend_half_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_read_data_reg;
    logic        m_fault_reg;

    // store: 16-bit words with byte lanes, registered read
    logic [15:0]            mem [STORE_WORDS];
    logic [STORE_WORDS-1:0] wvalid_reg;
    logic [15:0]            rd_data_reg;
    logic                   rd_vld_reg;
    logic [15:0]            rd_word;

    logic        accept;
    logic        len_ok, op_ok;
    logic        is_write, last_byte;
    logic [16:0] lk_addr;
    lk_t         lk;
    logic [5:0]  eff_off;
    logic [WI_W-1:0] wi;
    logic        wi_ok;
    logic [AW-1:0]   maddr;
    logic        is_const, is_tick;
    logic [7:0]  src_byte;
    logic [7:0]  tick_byte;
    logic [7:0]  wr_byte;
    logic [1:0]  wr_sel;
    logic        wr_ok;
    logic        mem_we, we_hi, we_lo;
    logic [7:0]  d_hi, d_lo;
    logic [7:0]  merge_byte;
    logic        load_out;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_fault     = m_fault_reg;

    assign len_ok = (s_length == 3'd1) || (s_length == 3'd2) || (s_length == 3'd4);
    assign op_ok  = (s_operation == OP_READ) || (s_operation == OP_WRITE);

    assign is_write  = (op_reg == OP_WRITE);
    assign last_byte = ({1'b0, k_reg} == (len_reg - 3'd1));

    // a write must sit in one entry, so it always looks up its first byte
    assign lk_addr = is_write ? {1'b0, addr_reg}
                              : ({1'b0, addr_reg} + 17'(k_reg));

    lmgm_lookup u_lookup (
        .addr (lk_addr),
        .lk   (lk)
    );

    assign eff_off  = is_write ? (lk.off + {4'b0, k_reg}) : lk.off;
    assign wi       = {1'b0, lk.idx} + {4'b0, eff_off[5:1]};
    assign wi_ok    = (wi < WI_W'(STORE_WORDS));
    assign maddr    = wi[AW-1:0];
    assign is_const = lk.sz[SZ_CONST_BIT];
    assign is_tick  = lk.sz[SZ_TICK_BIT];

    always_comb begin
        case (eff_off[1:0])
            2'd0:    tick_byte = ticks_reg[31:24];
            2'd1:    tick_byte = ticks_reg[23:16];
            2'd2:    tick_byte = ticks_reg[15:8];
            default: tick_byte = ticks_reg[7:0];
        endcase
    end

    // non-store byte; a store word past the end reads as zero
    always_comb begin
        if (is_const) begin
            src_byte = lm_const_byte(lk.sz, lk.idx, eff_off);
        end else if (is_tick) begin
            src_byte = tick_byte;
        end else begin
            src_byte = 8'h00;
        end
    end

    // write bytes go out most significant first
    assign wr_sel = 2'(len_reg - 3'd1 - {1'b0, k_reg});
    always_comb begin
        case (wr_sel)
            2'd0:    wr_byte = wdata_reg[7:0];
            2'd1:    wr_byte = wdata_reg[15:8];
            2'd2:    wr_byte = wdata_reg[23:16];
            default: wr_byte = wdata_reg[31:24];
        endcase
    end

    assign wr_ok = lk.hit && !is_const &&
                   (({1'b0, lk.off} + {4'b0, len_reg}) <= {1'b0, 6'(lk.sz & SZ_WIDTH)});

    // first write to a word fills the other lane with zero
    assign mem_we = (state_reg == ST_RUN) && is_write && wr_ok && wi_ok;
    assign we_hi  = mem_we && (!eff_off[0] || !wvalid_reg[maddr]);
    assign we_lo  = mem_we && ( eff_off[0] || !wvalid_reg[maddr]);
    assign d_hi   = eff_off[0] ? 8'h00 : wr_byte;
    assign d_lo   = eff_off[0] ? wr_byte : 8'h00;

    always_ff @(posedge aclk) begin
        if (we_hi) begin
            mem[maddr][15:8] <= d_hi;
        end
        if (we_lo) begin
            mem[maddr][7:0] <= d_lo;
        end
        rd_data_reg <= mem[maddr];
        rd_vld_reg  <= wvalid_reg[maddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvalid_reg <= '0;
        end else if (mem_we) begin
            wvalid_reg[maddr] <= 1'b1;
        end
    end

    assign rd_word    = rd_vld_reg ? rd_data_reg : 16'h0000;
    assign merge_byte = pend_mem_reg ? (pend_half_reg ? rd_word[7:0] : rd_word[15:8])
                                     : pend_byte_reg;

    assign load_out = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        fault_next      = fault_reg;
        pend_valid_next = 1'b0;
        pend_mem_next   = pend_mem_reg;
        pend_half_next  = pend_half_reg;
        pend_byte_next  = pend_byte_reg;

        if ((state_reg == ST_RUN || state_reg == ST_DRAIN) && pend_valid_reg) begin
            acc_next = {acc_reg[23:0], merge_byte};
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    k_next     = 2'd0;
                    acc_next   = '0;
                    fault_next = !(len_ok && op_ok);
                    state_next = (len_ok && op_ok) ? ST_RUN : ST_FIN;
                end
            end
            ST_RUN: begin
                if (is_write) begin
                    if (!wr_ok) begin
                        fault_next = 1'b1;
                        state_next = ST_FIN;
                    end else if (last_byte) begin
                        state_next = ST_FIN;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end else if (!lk.hit) begin
                    fault_next = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    pend_valid_next = 1'b1;
                    pend_mem_next   = !is_const && !is_tick && wi_ok;
                    pend_half_next  = eff_off[0];
                    pend_byte_next  = src_byte;
                    if (last_byte) begin
                        state_next = ST_DRAIN;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            default: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        acc_reg       <= acc_next;
        fault_reg     <= fault_next;
        pend_mem_reg  <= pend_mem_next;
        pend_half_reg <= pend_half_next;
        pend_byte_reg <= pend_byte_next;
        if (accept) begin
            op_reg    <= s_operation;
            addr_reg  <= s_address;
            len_reg   <= s_length;
            wdata_reg <= s_write_data;
            ticks_reg <= s_ticks;
        end
        if (load_out) begin
            m_fault_reg     <= fault_reg;
            m_read_data_reg <= (fault_reg || op_reg != OP_READ) ? 32'h0 : acc_reg;
        end
    end

    // faulted words never carry data; write words are zeroed as well
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fault |-> m_read_data == 32'h0)
        else $error("fault word with nonzero data");

    // store only written while stepping a write
    a_we_run: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == ST_RUN && op_reg == OP_WRITE)
        else $error("store write outside a write sequence");

    // no read byte left over once idle
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("pending byte while idle");

    // drain always moves straight on to FIN
    a_drain_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |=> state_reg == ST_FIN)
        else $error("drain did not finish");

    // a held result is not overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_read_data_reg))
        else $error("output word lost");

endmodule

>>> verif/lmgm_access_checker.sv
// lmgm_access_checker: watches both channels of the low-memory globals map, predicts
// each result word from a shadow copy of the range table and word store, and counts mismatches.
// Depends on lmgm_pkg for the operation codes.
`timescale 1ns / 1ps

module lmgm_access_checker import lmgm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_address,
    input  logic [2:0]  s_length,
    input  logic [31:0] s_write_data,
    input  logic [31:0] s_ticks,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_read_data,
    input  logic        m_fault,
    output int          mismatch_count,
    output int          results_waiting
);

    localparam int NUM_RANGES  = 41;
    localparam int SHADOW_SIZE = 88;

    localparam logic [7:0] KIND_CONST = 8'h80;
    localparam logic [7:0] KIND_TICK  = 8'h40;
    localparam logic [7:0] WIDTH_MASK = 8'h3F;

    localparam logic [15:0] RANGE_BASE [NUM_RANGES] = '{
        16'h0102, 16'h0106, 16'h0144, 16'h0146, 16'h014A, 16'h0154, 16'h016A,
        16'h0172, 16'h017A, 16'h0220, 16'h031A, 16'h0800, 16'h0804, 16'h0814,
        16'h0818, 16'h0824, 16'h0830, 16'h0834, 16'h0908, 16'h0910, 16'h0934,
        16'h0980, 16'h0984, 16'h09D6, 16'h09DA, 16'h09DC, 16'h09DE, 16'h09E6,
        16'h09EA, 16'h09EE, 16'h09F2, 16'h0A02, 16'h0A06, 16'h0A0E, 16'h0A34,
        16'h0A3C, 16'h0A60, 16'h0A64, 16'h0A68, 16'h0BAA, 16'h0BFE
    };

    localparam logic [7:0] RANGE_KIND [NUM_RANGES] = '{
        8'h84, 8'h02, 8'h02, 8'h04, 8'h0A, 8'h02, 8'h44,
        8'h02, 8'h02, 8'h02, 8'h83, 8'h04, 8'h04, 8'h04,
        8'h04, 8'h04, 8'h04, 8'h08, 8'h04, 8'h20, 8'h02,
        8'h04, 8'h82, 8'h04, 8'h02, 8'h02, 8'h04, 8'h04,
        8'h04, 8'h04, 8'h04, 8'h84, 8'h84, 8'h0E, 8'h08,
        8'h08, 8'h02, 8'h04, 8'h04, 8'h02, 8'h02
    };

    localparam logic [7:0] RANGE_SLOT [NUM_RANGES] = '{
        8'd72, 8'd0,  8'd1,  8'd2,  8'd4,  8'd9,  8'd10,
        8'd12, 8'd13, 8'd14, 8'hFF, 8'd15, 8'd17, 8'd19,
        8'd21, 8'd23, 8'd25, 8'd27, 8'd31, 8'd33, 8'd49,
        8'd50, 8'd3,  8'd52, 8'd54, 8'd55, 8'd56, 8'd58,
        8'd60, 8'd62, 8'd64, 8'h01, 8'hFF, 8'd66, 8'd73,
        8'd77, 8'd81, 8'd82, 8'd84, 8'd86, 8'd87
    };

    typedef struct {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [31:0] data;
        logic        fault;
    } access_result_t;

    logic [15:0]    shadow_words [SHADOW_SIZE];
    access_result_t pending_results [$];
    access_result_t got_result;
    access_result_t want_result;
    int             fails = 0;
    int             pending_count = 0;

    assign mismatch_count  = fails;
    assign results_waiting = pending_count;

    // bytes covered; a 3-wide constant is shown as a long
    function automatic int unsigned range_span(input int r);
        int unsigned w;
        w = RANGE_KIND[r] & WIDTH_MASK;
        range_span = (w == 3) ? 4 : w;
    endfunction

    // entries never overlap, so the scan direction does not matter
    function automatic int covering_range(input int unsigned a);
        covering_range = -1;
        for (int r = NUM_RANGES - 1; r >= 0; r--) begin
            if (a >= RANGE_BASE[r] && a < RANGE_BASE[r] + range_span(r))
                covering_range = r;
        end
    endfunction

    function automatic logic [7:0] range_byte(input int r, input int unsigned off,
                                              input logic [31:0] ticks);
        int unsigned w;
        int unsigned slot;
        logic [15:0] pattern;
        w = RANGE_KIND[r] & WIDTH_MASK;
        pattern = {{8{RANGE_SLOT[r][7]}}, RANGE_SLOT[r]};
        slot = RANGE_SLOT[r] + off / 2;
        if ((RANGE_KIND[r] & KIND_CONST) != 0) begin
            if (w < 2)
                range_byte = RANGE_SLOT[r];
            else if (w == 3 && off == 0)
                range_byte = 8'h00;
            else
                range_byte = off[0] ? pattern[7:0] : pattern[15:8];
        end else if ((RANGE_KIND[r] & KIND_TICK) != 0) begin
            range_byte = ticks >> (8 * (3 - (off % 4)));
        end else if (slot >= SHADOW_SIZE) begin
            range_byte = 8'h00;
        end else begin
            range_byte = off[0] ? shadow_words[slot][7:0] : shadow_words[slot][15:8];
        end
    endfunction

    // applies one access to the shadow store and returns its result word
    function automatic access_result_t apply_access(input logic [1:0] op,
                                                    input logic [15:0] addr,
                                                    input logic [2:0] len,
                                                    input logic [31:0] wdata,
                                                    input logic [31:0] ticks);
        access_result_t res;
        int             r;
        int unsigned    off;
        int unsigned    slot;
        logic [7:0]     b;
        res.op    = op;
        res.addr  = addr;
        res.data  = '0;
        res.fault = 1'b0;
        if (len != 3'd1 && len != 3'd2 && len != 3'd4) begin
            res.fault = 1'b1;
        end else if (op == OP_READ) begin
            for (int k = 0; k < len; k++) begin
                if (!res.fault) begin
                    r = covering_range(addr + k);
                    if (r < 0)
                        res.fault = 1'b1;
                    else
                        res.data = {res.data[23:0],
                                    range_byte(r, addr + k - RANGE_BASE[r], ticks)};
                end
            end
        end else if (op == OP_WRITE) begin
            r = covering_range(addr);
            if (r < 0 || (RANGE_KIND[r] & KIND_CONST) != 0) begin
                res.fault = 1'b1;
            end else begin
                off = addr - RANGE_BASE[r];
                if (off + len > (RANGE_KIND[r] & WIDTH_MASK)) begin
                    res.fault = 1'b1;
                end else begin
                    for (int k = 0; k < len; k++) begin
                        b    = wdata >> (8 * (len - 1 - k));
                        slot = RANGE_SLOT[r] + (off + k) / 2;
                        if (slot < SHADOW_SIZE) begin
                            if ((off + k) % 2 == 1)
                                shadow_words[slot][7:0] = b;
                            else
                                shadow_words[slot][15:8] = b;
                        end
                    end
                end
            end
        end else begin
            res.fault = 1'b1;
        end
        if (res.fault || op != OP_READ)
            res.data = '0;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SHADOW_SIZE; i++)
                shadow_words[i] = '0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word, expected none, got data %h fault %b",
                             $time, m_read_data, m_fault);
                end else begin
                    want_result = pending_results.pop_front();
                    if (m_read_data !== want_result.data) begin
                        fails++;
                        $display("%0t: op %0d addr %h read_data expected %h got %h",
                                 $time, want_result.op, want_result.addr,
                                 want_result.data, m_read_data);
                    end
                    if (m_fault !== want_result.fault) begin
                        fails++;
                        $display("%0t: op %0d addr %h fault expected %b got %b",
                                 $time, want_result.op, want_result.addr,
                                 want_result.fault, m_fault);
                    end
                end
            end
            if (s_valid && s_ready) begin
                got_result = apply_access(s_operation, s_address, s_length,
                                          s_write_data, s_ticks);
                pending_results.push_back(got_result);
            end
        end
        pending_count = pending_results.size();
    end

endmodule

>>> verif/low_memory_globals_map_core_tb.sv
// low_memory_globals_map_core_tb: stimulus and verdict for the low-memory globals map.
// Depends on lmgm_pkg, low_memory_globals_map_core and lmgm_access_checker.
`timescale 1ns / 1ps

module low_memory_globals_map_core_tb import lmgm_pkg::*; ();

    // operation codes the package leaves unnamed: both must fault
    localparam logic [1:0] OP_EXEC  = 2'd2;
    localparam logic [1:0] OP_UNDEF = 2'd3;

    // random words per idle phase (three phases, about 800 words total)
    localparam int PHASE_WORDS = 267;

    // address windows around the mapped ranges; random accesses land here so
    // most of them hit stored entries, constants, the tick counter and the gaps
    localparam int NUM_WINDOWS = 10;
    localparam logic [15:0] WIN_LO [NUM_WINDOWS] = '{
        16'h0100, 16'h0218, 16'h0318, 16'h07FC, 16'h0904,
        16'h097C, 16'h09D0, 16'h0A30, 16'h0BA8, 16'h0BF8
    };
    localparam logic [15:0] WIN_HI [NUM_WINDOWS] = '{
        16'h0180, 16'h0228, 16'h0320, 16'h0840, 16'h0940,
        16'h0990, 16'h0A20, 16'h0A70, 16'h0BB0, 16'h0C04
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [15:0] s_address;
    logic [2:0]  s_length;
    logic [31:0] s_write_data;
    logic [31:0] s_ticks;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_read_data;
    logic        m_fault;

    int mismatch_count;
    int results_waiting;

    // percent of cycles each side holds off
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    low_memory_globals_map_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_address    (s_address),
        .s_length     (s_length),
        .s_write_data (s_write_data),
        .s_ticks      (s_ticks),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_fault      (m_fault)
    );

    lmgm_access_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_address       (s_address),
        .s_length        (s_length),
        .s_write_data    (s_write_data),
        .s_ticks         (s_ticks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_fault         (m_fault),
        .mismatch_count  (mismatch_count),
        .results_waiting (results_waiting)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // result side back-pressure; redrawn every falling edge
    initial m_ready = 1'b0;
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Present one word on the input channel. Entered just after a rising edge
    // (or at start); returns just after the rising edge that accepted it.
    // The sender may idle first; valid is then held with a stable payload.
    task automatic send_word(input logic [1:0] op, input logic [15:0] addr,
                             input logic [2:0] len, input logic [31:0] wdata,
                             input logic [31:0] ticks);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_address    <= addr;
        s_length     <= len;
        s_write_data <= wdata;
        s_ticks      <= ticks;
        do @(posedge aclk); while (!s_ready);
    endtask

    // watchdog: far beyond the slowest legal run
    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int          sel;
        int          win;
        logic [1:0]  op;
        logic [15:0] addr;
        logic [2:0]  len;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = OP_READ;
        s_address    = '0;
        s_length     = 3'd1;
        s_write_data = '0;
        s_ticks      = '0;

        // synchronous reset, released off-edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed words ----
        // constant word 72, repeated: 00 48 00 48
        send_word(OP_READ,  16'h0102, 3'd4, $urandom, $urandom);
        // 3-wide constant is a long whose top byte is zero
        send_word(OP_READ,  16'h031A, 3'd4, $urandom, $urandom);
        // 2-wide constant, positive index
        send_word(OP_READ,  16'h0984, 3'd2, $urandom, $urandom);
        // negative index sign-extends to all ones
        send_word(OP_READ,  16'h0A06, 3'd4, $urandom, $urandom);
        // tick counter follows the ticks input
        send_word(OP_READ,  16'h016A, 3'd4, $urandom, 32'hFFFF_FFFF);
        // store extremes: all ones, then a pattern at the tail of the 32-byte range
        send_word(OP_WRITE, 16'h0910, 3'd4, 32'hFFFF_FFFF, $urandom);
        send_word(OP_WRITE, 16'h092C, 3'd4, 32'hA5C3_3C5A, $urandom);
        send_word(OP_READ,  16'h0910, 3'd4, $urandom, $urandom);
        send_word(OP_READ,  16'h092D, 3'd2, $urandom, $urandom);
        // write running off the end of its entry into a gap
        send_word(OP_WRITE, 16'h092E, 3'd4, 32'h1234_5678, $urandom);
        // write straddling the end of an entry
        send_word(OP_WRITE, 16'h0107, 3'd2, 32'h0000_BEEF, $urandom);
        // write into a constant entry
        send_word(OP_WRITE, 16'h0102, 3'd2, 32'h0000_FFFF, $urandom);
        // write to the tick counter is taken, but reads still show ticks
        send_word(OP_WRITE, 16'h016A, 3'd4, 32'h1234_5678, $urandom);
        send_word(OP_READ,  16'h016A, 3'd4, $urandom, 32'h0000_0000);
        // execute fetch and the undefined operation
        send_word(OP_EXEC,  16'h0106, 3'd2, $urandom, $urandom);
        send_word(OP_UNDEF, 16'h0106, 3'd1, $urandom, $urandom);
        // illegal lengths on both operations
        send_word(OP_READ,  16'h0910, 3'd0, $urandom, $urandom);
        send_word(OP_WRITE, 16'h0910, 3'd3, $urandom, $urandom);
        send_word(OP_READ,  16'h0910, 3'd5, $urandom, $urandom);
        send_word(OP_WRITE, 16'h0910, 3'd6, $urandom, $urandom);
        send_word(OP_READ,  16'h0910, 3'd7, $urandom, $urandom);
        // uncovered byte, and a read that draws from two different entries
        send_word(OP_READ,  16'h0000, 3'd1, $urandom, $urandom);
        send_word(OP_READ,  16'h0104, 3'd4, $urandom, $urandom);
        // top of the address space: the second byte lies past FFFF and matches no entry
        send_word(OP_READ,  16'hFFFF, 3'd2, $urandom, $urandom);
        send_word(OP_WRITE, 16'hFFFF, 3'd1, 32'h0000_00FF, $urandom);

        // ---- random words, three back-pressure phases ----
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 32;
                    rx_idle_pct = 71;
                end
                1: begin
                    tx_idle_pct = 71;
                    rx_idle_pct = 32;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (PHASE_WORDS) begin
                sel = $urandom_range(0, 99);
                case ($urandom_range(0, 2))
                    0:       len = 3'd1;
                    1:       len = 3'd2;
                    default: len = 3'd4;
                endcase
                win  = $urandom_range(0, NUM_WINDOWS - 1);
                addr = 16'($urandom_range(WIN_LO[win], WIN_HI[win]));
                op   = ($urandom_range(0, 99) < 55) ? OP_READ : OP_WRITE;
                if (sel < 6) begin
                    // noise over the whole field space
                    op   = 2'($urandom_range(0, 3));
                    addr = 16'($urandom_range(0, 65535));
                    len  = 3'($urandom_range(0, 7));
                end else if (sel < 9) begin
                    op = ($urandom_range(0, 1) != 0) ? OP_EXEC : OP_UNDEF;
                end else if (sel < 12) begin
                    case ($urandom_range(0, 4))
                        0:       len = 3'd0;
                        1:       len = 3'd3;
                        2:       len = 3'd5;
                        3:       len = 3'd6;
                        default: len = 3'd7;
                    endcase
                end else if (sel < 80) begin
                    // aligned to size: writes usually fit a stored entry
                    addr = addr & ~(16'(len) - 16'd1);
                end
                send_word(op, addr, len, $urandom, $urandom);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then wait on for any stray result word
        while (results_waiting != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);

        if (mismatch_count == 0 && results_waiting == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
